### design/sfs_pkg.sv
// Package for the substring filter selector: sizes, mode codes, item structs,
// controller states and the command/status structs between controller and datapath.
// Depends on nothing.
package sfs_pkg;

	localparam int MAX_ENTRIES  = 64;
	localparam int NAME_CHARS   = 48;
	localparam int FILTER_CHARS = 24;

	localparam int NAME_BYTES = MAX_ENTRIES * NAME_CHARS;
	localparam int ADDR_W     = $clog2(NAME_BYTES);
	localparam int ENT_W      = $clog2(MAX_ENTRIES);
	localparam int CNT_W      = $clog2(MAX_ENTRIES + 1);
	localparam int POS_W      = $clog2(NAME_CHARS);
	localparam int FLT_W      = $clog2(FILTER_CHARS);
	localparam int FCNT_W     = $clog2(FILTER_CHARS + 1);

	localparam logic [7:0] CHAR_LO = 8'h20;
	localparam logic [7:0] CHAR_HI = 8'h7F;

	// Item modes; codes above MODE_HOME do nothing.
	typedef enum logic [3:0] {
		MODE_UP        = 4'd0,
		MODE_DOWN      = 4'd1,
		MODE_ENTER     = 4'd2,
		MODE_BACKSPACE = 4'd3,
		MODE_ESCAPE    = 4'd4,
		MODE_CHAR      = 4'd5,
		MODE_NAME      = 4'd6,
		MODE_COUNT     = 4'd7,
		MODE_TOUCH     = 4'd8,
		MODE_HOME      = 4'd9
	} mode_t;

	typedef struct packed {
		logic [3:0] mode;
		logic [7:0] char_code;
		logic [5:0] entry_index;
		logic [5:0] char_pos;
		logic [6:0] new_count;
		logic [5:0] row;
	} in_item_t;

	typedef struct packed {
		logic [6:0] match_total;
		logic [5:0] selection;
		logic [5:0] selected_entry;
		logic [4:0] filter_length;
		logic       launch;
		logic [5:0] launch_entry;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_FETCH,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic clear_step;
		logic take;
		logic scan_start;
		logic scan;
		logic fetch;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic rebuild_req;
		logic scan_done;
		logic out_free;
	} status_t;

	// Fold ASCII upper-case letters to lower case.
	function automatic logic [7:0] fold(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

endpackage

### design/sfs_ctrl.sv
// Controller state machine of the substring filter selector.
// Depends on sfs_pkg; drives commands to sfs_datapath and reads its status.
module sfs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  sfs_pkg::status_t status,
	output sfs_pkg::cmd_t   cmd
);

	sfs_pkg::state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfs_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			sfs_pkg::ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (status.clear_done) begin
					state_d = sfs_pkg::ST_IDLE;
				end
			end
			sfs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = status.rebuild_req ? sfs_pkg::ST_START : sfs_pkg::ST_FETCH;
				end
			end
			sfs_pkg::ST_START: begin
				cmd.scan_start = 1'b1;
				state_d        = sfs_pkg::ST_SCAN;
			end
			sfs_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_done) begin
					state_d = sfs_pkg::ST_FETCH;
				end
			end
			sfs_pkg::ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = sfs_pkg::ST_FINISH;
			end
			sfs_pkg::ST_FINISH: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = sfs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sfs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### design/sfs_datapath.sv
// Datapath of the substring filter selector: name memory, filter registers,
// shift-and matcher, match list memory, selection and the output register.
// Depends on sfs_pkg; steered by sfs_ctrl through cmd_t and status_t.
module sfs_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  sfs_pkg::cmd_t      cmd,
	output sfs_pkg::status_t   status,
	input  sfs_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output sfs_pkg::out_item_t out_data
);

	localparam int AW = sfs_pkg::ADDR_W;
	localparam int EW = sfs_pkg::ENT_W;
	localparam int CW = sfs_pkg::CNT_W;
	localparam int PW = sfs_pkg::POS_W;
	localparam int FW = sfs_pkg::FLT_W;
	localparam int FCW = sfs_pkg::FCNT_W;
	localparam int FC = sfs_pkg::FILTER_CHARS;

	// Memories.
	logic [7:0]    name_mem [sfs_pkg::NAME_BYTES];
	logic [EW-1:0] match_mem [sfs_pkg::MAX_ENTRIES];

	// Control state.
	logic [AW-1:0]  clr_q;
	logic [FCW-1:0] fc_q;
	logic [CW-1:0]  mc_q;
	logic [CW-1:0]  reg_cnt_q;
	logic [EW-1:0]  sel_q;
	logic           launch_q;
	logic [CW-1:0]  ent_q;
	logic [PW-1:0]  pos_q;
	logic           issue_q;
	logic           v_s1;
	logic           out_valid_q;

	// Payload state.
	logic [7:0]    filt_q [FC];
	logic [7:0]    rdata_s1;
	logic          first_s1;
	logic          last_s1;
	logic [EW-1:0] ent_s1;
	logic [FC-1:0] d_q;
	logic          found_q;
	logic          alive_q;
	logic [EW-1:0] ml_rd_q;
	sfs_pkg::out_item_t out_q;

	// Decode of the item at the input.
	logic           printable;
	logic [CW-1:0]  sat_cnt;
	logic [AW-1:0]  wr_addr;
	logic [AW-1:0]  rd_addr;
	logic           rebuild_req;

	assign printable = in_data.char_code >= sfs_pkg::CHAR_LO
		&& in_data.char_code < sfs_pkg::CHAR_HI;
	assign sat_cnt = (in_data.new_count > CW'(sfs_pkg::MAX_ENTRIES))
		? CW'(sfs_pkg::MAX_ENTRIES) : CW'(in_data.new_count);
	assign wr_addr = AW'(in_data.entry_index) * AW'(sfs_pkg::NAME_CHARS) + AW'(in_data.char_pos);
	assign rd_addr = AW'(ent_q) * AW'(sfs_pkg::NAME_CHARS) + AW'(pos_q);

	// A rebuild follows every filter change, every count change and every home item.
	always_comb begin
		rebuild_req = 1'b0;
		case (in_data.mode)
			sfs_pkg::MODE_BACKSPACE, sfs_pkg::MODE_ESCAPE: rebuild_req = fc_q != '0;
			sfs_pkg::MODE_CHAR:  rebuild_req = printable && fc_q < FCW'(FC);
			sfs_pkg::MODE_COUNT: rebuild_req = sat_cnt != reg_cnt_q;
			sfs_pkg::MODE_HOME:  rebuild_req = 1'b1;
			default:             rebuild_req = 1'b0;
		endcase
	end

	assign status.rebuild_req = rebuild_req;
	assign status.clear_done  = clr_q == AW'(sfs_pkg::NAME_BYTES - 1);
	assign status.scan_done   = !issue_q && !v_s1;
	assign status.out_free    = !out_valid_q || out_ready;

	// Name memory: the clearing pass after reset, then name writes; one read per cycle.
	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			name_mem[clr_q] <= 8'h00;
		end else if (cmd.take && in_data.mode == sfs_pkg::MODE_NAME
			&& in_data.char_pos < 6'(sfs_pkg::NAME_CHARS)) begin
			name_mem[wr_addr] <= in_data.char_code;
		end
		rdata_s1 <= name_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_step && !status.clear_done) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// Shift-and matcher over the byte read in the previous cycle.
	logic [FC-1:0] d_cur, d_nxt, mask;
	logic          found_cur, alive_cur, nz, hit;
	logic [FW-1:0] fidx;

	always_comb begin
		d_cur     = first_s1 ? '0 : d_q;
		found_cur = first_s1 ? 1'b0 : found_q;
		alive_cur = first_s1 ? 1'b1 : alive_q;
		nz        = rdata_s1 != 8'h00;
		for (int k = 0; k < FC; k++) begin
			mask[k] = sfs_pkg::fold(rdata_s1) == sfs_pkg::fold(filt_q[k]);
		end
		d_nxt = ((d_cur << 1) | FC'(1)) & mask;
		fidx  = FW'(fc_q - FCW'(1));
		hit   = alive_cur && nz && (fc_q == '0 || d_nxt[fidx]);
	end

	always_ff @(posedge clk) begin
		first_s1 <= pos_q == '0;
		last_s1  <= pos_q == PW'(sfs_pkg::NAME_CHARS - 1);
		ent_s1   <= ent_q[EW-1:0];
		if (v_s1) begin
			d_q     <= d_nxt;
			found_q <= found_cur || hit;
			alive_q <= alive_cur && nz;
		end
	end

	// Match list memory: appended during a scan, read at the selection.
	always_ff @(posedge clk) begin
		if (v_s1 && last_s1 && (found_cur || hit)) begin
			match_mem[mc_q[EW-1:0]] <= ent_s1;
		end
		if (cmd.fetch) begin
			ml_rd_q <= match_mem[sel_q];
		end
	end

	// Filter characters; those at or beyond the count are never used.
	always_ff @(posedge clk) begin
		if (cmd.take && in_data.mode == sfs_pkg::MODE_CHAR && printable && fc_q < FCW'(FC)) begin
			filt_q[fc_q[FW-1:0]] <= in_data.char_code;
		end
	end

	// Item updates, scan sequencing and selection clamping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q      <= '0;
			mc_q      <= '0;
			reg_cnt_q <= '0;
			sel_q     <= '0;
			launch_q  <= 1'b0;
			ent_q     <= '0;
			pos_q     <= '0;
			issue_q   <= 1'b0;
			v_s1      <= 1'b0;
		end else begin
			v_s1 <= cmd.scan && issue_q;
			if (cmd.take) begin
				launch_q <= 1'b0;
				case (in_data.mode)
					sfs_pkg::MODE_UP: begin
						if (mc_q != '0 && sel_q != '0) begin
							sel_q <= sel_q - EW'(1);
						end
					end
					sfs_pkg::MODE_DOWN: begin
						if (mc_q != '0 && CW'(sel_q) + CW'(1) < mc_q) begin
							sel_q <= sel_q + EW'(1);
						end
					end
					sfs_pkg::MODE_ENTER: begin
						launch_q <= CW'(sel_q) < mc_q;
					end
					sfs_pkg::MODE_BACKSPACE: begin
						if (fc_q != '0) begin
							fc_q <= fc_q - FCW'(1);
						end
					end
					sfs_pkg::MODE_ESCAPE, sfs_pkg::MODE_HOME: begin
						fc_q <= '0;
					end
					sfs_pkg::MODE_CHAR: begin
						if (printable && fc_q < FCW'(FC)) begin
							fc_q <= fc_q + FCW'(1);
						end
					end
					sfs_pkg::MODE_COUNT: begin
						reg_cnt_q <= sat_cnt;
					end
					sfs_pkg::MODE_TOUCH: begin
						if (CW'(in_data.row) < mc_q) begin
							sel_q    <= in_data.row;
							launch_q <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.scan_start) begin
				ent_q   <= '0;
				pos_q   <= '0;
				mc_q    <= '0;
				issue_q <= reg_cnt_q != '0;
			end
			if (cmd.scan && issue_q) begin
				if (pos_q == PW'(sfs_pkg::NAME_CHARS - 1)) begin
					pos_q <= '0;
					ent_q <= ent_q + CW'(1);
					if (ent_q + CW'(1) == reg_cnt_q) begin
						issue_q <= 1'b0;
					end
				end else begin
					pos_q <= pos_q + PW'(1);
				end
			end
			if (v_s1 && last_s1 && (found_cur || hit)) begin
				mc_q <= mc_q + CW'(1);
			end
			if (cmd.scan && status.scan_done && CW'(sel_q) >= mc_q) begin
				sel_q <= (mc_q == '0) ? '0 : EW'(mc_q - CW'(1));
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.match_total    <= mc_q;
			out_q.selection      <= sel_q;
			out_q.selected_entry <= (mc_q != '0) ? ml_rd_q : '0;
			out_q.filter_length  <= fc_q;
			out_q.launch         <= launch_q;
			out_q.launch_entry   <= launch_q ? ml_rd_q : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Checks.
	a_mc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.scan_start |-> mc_q <= reg_cnt_q)
		else $error("match count exceeds entry count");
	a_sel_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.scan && !cmd.scan_start |-> (sel_q == '0 || CW'(sel_q) < mc_q))
		else $error("selection outside the match list");
	a_fc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= FCW'(FC))
		else $error("filter count beyond capacity");
	a_launch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.launch |-> out_q.launch_entry == out_q.selected_entry)
		else $error("launched entry differs from selected entry");

endmodule

### design/substring_filter_selector_unit.sv
// Top level of the substring filter selector.
// Depends on sfs_pkg, sfs_ctrl and sfs_datapath.
//
// Usage:
//   Items enter on in_valid/in_ready with an in_item_t payload; every item
//   yields exactly one result on out_valid/out_ready as an out_item_t.
//   An item that does not rebuild the match list (moves, enter, touch, name
//   writes, ignored keys) passes from acceptance through the fetch of the
//   selected match and the load of the output register, and the next item
//   is accepted once the controller is back in idle. An item that rebuilds
//   the list (filter changes, count changes, home) also scans the first N
//   names, N being the registered entry count: the scan reads the name
//   memory one byte per cycle through its single read port. One item is in
//   work at a time. After reset the name memory is cleared one byte per
//   cycle, during which in_ready stays low.
//   Results sit in an output register; the next item is accepted while a
//   result waits. If the receiver stalls, the following item finishes its
//   work and then holds until the register is free.
module substring_filter_selector_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sfs_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output sfs_pkg::out_item_t out_data
);

	sfs_pkg::cmd_t    cmd;
	sfs_pkg::status_t status;

	// Controller.
	sfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath.
	sfs_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

### tb/sv/substring_filter_selector_unit_tb.sv
// Testbench for substring_filter_selector_unit: directed table plus random items,
// checked item by item against a behavioral predictor of the filter and selection.
// Depends on sfs_pkg and the substring_filter_selector_unit RTL.
`timescale 1ns / 100ps

module substring_filter_selector_unit_tb;

	localparam int CYCLE_LIMIT = 2000000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	sfs_pkg::in_item_t  in_data;
	logic               out_valid;
	logic               out_ready;
	sfs_pkg::out_item_t out_data;

	substring_filter_selector_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// Predictor copy of the block state.
	logic [7:0] names [sfs_pkg::MAX_ENTRIES*sfs_pkg::NAME_CHARS];
	logic [7:0] filt [sfs_pkg::FILTER_CHARS];
	int         filt_len;
	int         hits [sfs_pkg::MAX_ENTRIES];
	int         hit_count;
	int         sel_pos;
	int         reg_count;

	sfs_pkg::out_item_t pending_results[$];
	int         errors;
	int         checked;
	int         launches;
	longint     cycles;
	int         send_idle_pct;
	int         recv_stall_pct;
	bit         hold_off;

	typedef struct {
		sfs_pkg::in_item_t  item;
		bit                 has_gold;
		sfs_pkg::out_item_t gold;
	} vector_t;

	vector_t vectors[$];

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [7:0] lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
	endfunction

	function automatic bit name_has_filter(input int e);
		int len;
		int k;
		len = 0;
		while (len < sfs_pkg::NAME_CHARS && names[e*sfs_pkg::NAME_CHARS+len] != 8'h00) len++;
		if (len == 0) return 1'b0;
		if (filt_len == 0) return 1'b1;
		for (int s = 0; s < len; s++) begin
			k = 0;
			while (k < filt_len && s + k < len &&
			       lower(names[e*sfs_pkg::NAME_CHARS+s+k]) == lower(filt[k])) k++;
			if (k == filt_len) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void rebuild_hits();
		hit_count = 0;
		for (int i = 0; i < reg_count; i++) begin
			if (name_has_filter(i)) begin
				hits[hit_count] = i;
				hit_count++;
			end
		end
		if (sel_pos >= hit_count) sel_pos = (hit_count > 0) ? hit_count - 1 : 0;
	endfunction

	// Advance the predictor by one item and return the expected result.
	function automatic sfs_pkg::out_item_t predict_step(input sfs_pkg::in_item_t it);
		sfs_pkg::out_item_t r;
		int                 cnt;
		r = '0;
		case (it.mode)
			sfs_pkg::MODE_UP: begin
				if (hit_count > 0 && sel_pos > 0) sel_pos--;
			end
			sfs_pkg::MODE_DOWN: begin
				if (hit_count > 0 && sel_pos + 1 < hit_count) sel_pos++;
			end
			sfs_pkg::MODE_ENTER: begin
				if (sel_pos < hit_count) begin
					r.launch = 1'b1;
					r.launch_entry = 6'(hits[sel_pos]);
				end
			end
			sfs_pkg::MODE_BACKSPACE: begin
				if (filt_len > 0) begin
					filt_len--;
					filt[filt_len] = 8'h00;
					rebuild_hits();
				end
			end
			sfs_pkg::MODE_ESCAPE: begin
				if (filt_len > 0) begin
					foreach (filt[i]) filt[i] = 8'h00;
					filt_len = 0;
					rebuild_hits();
				end
			end
			sfs_pkg::MODE_CHAR: begin
				if (it.char_code >= sfs_pkg::CHAR_LO && it.char_code < sfs_pkg::CHAR_HI &&
				    filt_len < sfs_pkg::FILTER_CHARS) begin
					filt[filt_len] = it.char_code;
					filt_len++;
					rebuild_hits();
				end
			end
			sfs_pkg::MODE_NAME: begin
				if (it.entry_index < sfs_pkg::MAX_ENTRIES && it.char_pos < sfs_pkg::NAME_CHARS)
					names[it.entry_index*sfs_pkg::NAME_CHARS+it.char_pos] = it.char_code;
			end
			sfs_pkg::MODE_COUNT: begin
				cnt = (it.new_count > sfs_pkg::MAX_ENTRIES) ? sfs_pkg::MAX_ENTRIES
				                                             : int'(it.new_count);
				if (cnt != reg_count) begin
					reg_count = cnt;
					rebuild_hits();
				end
			end
			sfs_pkg::MODE_TOUCH: begin
				if (it.row < hit_count) begin
					sel_pos = it.row;
					r.launch = 1'b1;
					r.launch_entry = 6'(hits[it.row]);
				end
			end
			sfs_pkg::MODE_HOME: begin
				foreach (filt[i]) filt[i] = 8'h00;
				filt_len = 0;
				rebuild_hits();
			end
			default: begin
			end
		endcase
		r.match_total = 7'(hit_count);
		r.selection = 6'(sel_pos);
		r.selected_entry = (hit_count > 0 && sel_pos < hit_count) ? 6'(hits[sel_pos]) : 6'(0);
		r.filter_length = 5'(filt_len);
		return r;
	endfunction

	function automatic sfs_pkg::in_item_t make_item(input sfs_pkg::mode_t m,
	                                                input logic [7:0] ch,
	                                                input int ent, input int pos,
	                                                input int cnt, input int rw);
		sfs_pkg::in_item_t it;
		it.mode = m;
		it.char_code = ch;
		it.entry_index = 6'(ent);
		it.char_pos = 6'(pos);
		it.new_count = 7'(cnt);
		it.row = 6'(rw);
		return it;
	endfunction

	function automatic sfs_pkg::out_item_t make_result(input int tot, input int sel,
	                                                   input int se, input int fl,
	                                                   input bit la, input int le);
		sfs_pkg::out_item_t r;
		r.match_total = 7'(tot);
		r.selection = 6'(sel);
		r.selected_entry = 6'(se);
		r.filter_length = 5'(fl);
		r.launch = la;
		r.launch_entry = 6'(le);
		return r;
	endfunction

	function automatic void add_row(input sfs_pkg::in_item_t it, input bit has_gold,
	                                input sfs_pkg::out_item_t gold);
		vector_t v;
		v.item = it;
		v.has_gold = has_gold;
		v.gold = gold;
		vectors.push_back(v);
	endfunction

	// Random item: mostly name writes into a small alphabet and filter keys.
	function automatic sfs_pkg::in_item_t random_item();
		sfs_pkg::in_item_t it;
		int                pick;
		logic [63:0]       rnd;
		logic [7:0]        letters [6];
		letters = '{8'h61, 8'h62, 8'h41, 8'h42, 8'h63, 8'h00};
		rnd = {$urandom, $urandom};
		it = rnd[$bits(sfs_pkg::in_item_t)-1:0];
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			it.mode = sfs_pkg::MODE_NAME;
			it.entry_index = 6'($urandom_range(0, 9));
			it.char_pos = 6'($urandom_range(0, 5));
			it.char_code = letters[$urandom_range(0, 5)];
			if ($urandom_range(0, 9) == 0) begin
				it.entry_index = 6'($urandom);
				it.char_pos = 6'($urandom);
				it.char_code = 8'($urandom);
			end
		end else if (pick < 50) begin
			it.mode = sfs_pkg::MODE_CHAR;
			it.char_code = ($urandom_range(0, 4) == 0) ? 8'($urandom)
			                                           : letters[$urandom_range(0, 4)];
		end else if (pick < 58) begin
			it.mode = sfs_pkg::MODE_COUNT;
			it.new_count = ($urandom_range(0, 9) == 0) ? 7'($urandom)
			                                           : 7'($urandom_range(0, 10));
		end else if (pick < 64) begin
			it.mode = sfs_pkg::MODE_BACKSPACE;
		end else if (pick < 72) begin
			it.mode = sfs_pkg::MODE_TOUCH;
			it.row = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 6));
		end else if (pick < 95) begin
			it.mode = 4'($urandom_range(0, 4));
			if ($urandom_range(0, 9) == 0) it.mode = sfs_pkg::MODE_HOME;
		end else begin
			it.mode = 4'($urandom_range(10, 15));
		end
		return it;
	endfunction

	// Offer one item; valid drops only while the sender idles.
	task automatic send_item(input sfs_pkg::in_item_t it, input bit has_gold,
	                         input sfs_pkg::out_item_t gold);
		sfs_pkg::out_item_t r;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		r = predict_step(it);
		pending_results.push_back(has_gold ? gold : r);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Receiver: random stalls, or a long hold-off when requested.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_off) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Result checker.
	always @(posedge clk) begin
		sfs_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %p", $time, out_data);
				errors++;
			end else begin
				want = pending_results.pop_front();
				checked++;
				if (out_data.launch) launches++;
				if (out_data.match_total !== want.match_total) begin
					$display("%0t: match_total expected %0d actual %0d", $time,
					         want.match_total, out_data.match_total);
					errors++;
				end
				if (out_data.selection !== want.selection) begin
					$display("%0t: selection expected %0d actual %0d", $time,
					         want.selection, out_data.selection);
					errors++;
				end
				if (out_data.selected_entry !== want.selected_entry) begin
					$display("%0t: selected_entry expected %0d actual %0d", $time,
					         want.selected_entry, out_data.selected_entry);
					errors++;
				end
				if (out_data.filter_length !== want.filter_length) begin
					$display("%0t: filter_length expected %0d actual %0d", $time,
					         want.filter_length, out_data.filter_length);
					errors++;
				end
				if (out_data.launch !== want.launch) begin
					$display("%0t: launch expected %0d actual %0d", $time,
					         want.launch, out_data.launch);
					errors++;
				end
				if (out_data.launch_entry !== want.launch_entry) begin
					$display("%0t: launch_entry expected %0d actual %0d", $time,
					         want.launch_entry, out_data.launch_entry);
					errors++;
				end
			end
		end
	end

	// Cycle limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("substring_filter_selector_unit_tb: errors");
			$finish;
		end
	end

	// Long receiver hold-off, counted here while the sender keeps offering items.
	task automatic long_hold();
		hold_off = 1'b1;
		repeat (400) @(posedge clk);
		hold_off = 1'b0;
	endtask

	initial begin
		sfs_pkg::out_item_t nil;
		int                 phase_pct [4][2];
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		errors = 0;
		checked = 0;
		launches = 0;
		cycles = 0;
		hold_off = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		foreach (names[i]) names[i] = 8'h00;
		foreach (filt[i]) filt[i] = 8'h00;
		foreach (hits[i]) hits[i] = 0;
		filt_len = 0;
		hit_count = 0;
		sel_pos = 0;
		reg_count = 0;
		nil = '0;
		phase_pct = '{'{0, 0}, '{60, 0}, '{0, 60}, '{38, 38}};

		// Directed table; fixed results only where obvious.
		add_row(make_item(sfs_pkg::MODE_UP, 8'h00, 0, 0, 0, 0), 1,
		        make_result(0, 0, 0, 0, 0, 0));
		add_row(make_item(sfs_pkg::MODE_DOWN, 8'h00, 0, 0, 0, 0), 1,
		        make_result(0, 0, 0, 0, 0, 0));
		add_row(make_item(sfs_pkg::MODE_ENTER, 8'h00, 0, 0, 0, 0), 1,
		        make_result(0, 0, 0, 0, 0, 0));
		add_row(make_item(sfs_pkg::MODE_BACKSPACE, 8'h00, 0, 0, 0, 0), 1,
		        make_result(0, 0, 0, 0, 0, 0));
		add_row(make_item(sfs_pkg::MODE_ESCAPE, 8'h00, 0, 0, 0, 0), 1,
		        make_result(0, 0, 0, 0, 0, 0));
		add_row(make_item(sfs_pkg::MODE_NAME, 8'h41, 0, 0, 0, 0), 0, nil);
		add_row(make_item(sfs_pkg::MODE_NAME, 8'h62, 0, 1, 0, 0), 0, nil);
		add_row(make_item(sfs_pkg::MODE_NAME, 8'hFF, 63, 47, 0, 0), 0, nil);
		add_row(make_item(sfs_pkg::MODE_NAME, 8'h7A, 1, 0, 0, 0), 0, nil);
		add_row(make_item(sfs_pkg::MODE_NAME, 8'h61, 2, 63, 0, 0), 0, nil);
		add_row(make_item(sfs_pkg::MODE_COUNT, 8'h00, 0, 0, 127, 0), 0, nil);
		add_row(make_item(sfs_pkg::MODE_COUNT, 8'h00, 0, 0, 64, 0), 0, nil);
		add_row(make_item(sfs_pkg::MODE_DOWN, 8'h00, 0, 0, 0, 0), 0, nil);
		add_row(make_item(sfs_pkg::MODE_DOWN, 8'h00, 0, 0, 0, 0), 0, nil);
		add_row(make_item(sfs_pkg::MODE_DOWN, 8'h00, 0, 0, 0, 0), 0, nil);
		add_row(make_item(sfs_pkg::MODE_CHAR, 8'h1F, 0, 0, 0, 0), 0, nil);
		add_row(make_item(sfs_pkg::MODE_CHAR, 8'h7F, 0, 0, 0, 0), 0, nil);
		add_row(make_item(sfs_pkg::MODE_CHAR, 8'h42, 0, 0, 0, 0), 0, nil);
		add_row(make_item(sfs_pkg::MODE_ENTER, 8'h00, 0, 0, 0, 0), 0, nil);
		add_row(make_item(sfs_pkg::MODE_TOUCH, 8'h00, 0, 0, 0, 63), 0, nil);
		add_row(make_item(sfs_pkg::MODE_TOUCH, 8'h00, 0, 0, 0, 0), 0, nil);
		add_row(make_item(sfs_pkg::MODE_BACKSPACE, 8'h00, 0, 0, 0, 0), 0, nil);
		add_row(make_item(sfs_pkg::mode_t'(4'd15), 8'hFF, 63, 63, 127, 63), 0, nil);
		add_row(make_item(sfs_pkg::MODE_HOME, 8'h00, 0, 0, 0, 0), 0, nil);
		add_row(make_item(sfs_pkg::MODE_COUNT, 8'h00, 0, 0, 3, 0), 0, nil);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, no idling.
		foreach (vectors[i]) begin
			send_item(vectors[i].item, vectors[i].has_gold, vectors[i].gold);
		end
		wait_drained();

		// A run of 24 typed characters fills the filter, then one more.
		for (int i = 0; i < sfs_pkg::FILTER_CHARS + 1; i++)
			send_item(make_item(sfs_pkg::MODE_CHAR, 8'(8'h20 + i), 0, 0, 0, 0), 1'b0, nil);
		send_item(make_item(sfs_pkg::MODE_ESCAPE, 8'h00, 0, 0, 0, 0), 1'b0, nil);
		wait_drained();

		// Random phases with different idling patterns.
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = phase_pct[p][0];
			recv_stall_pct = phase_pct[p][1];
			if (p == 1) begin
				fork
					long_hold();
				join_none
			end
			for (int i = 0; i < 22; i++) send_item(random_item(), 1'b0, nil);
			wait_drained();
		end

		wait_drained();
		repeat (50) @(posedge clk);
		$display("Covered %0d results (%0d launches) over four idling phases,", checked, launches);
		$display("including a long output hold-off and a full-filter run.");
		if (errors == 0 && pending_results.size() == 0) begin
			$display("substring_filter_selector_unit_tb: clean");
		end else begin
			$display("substring_filter_selector_unit_tb: errors");
		end
		$finish;
	end

endmodule
